// ===== hw/rtl/omni_drive_wheel_mixer_macros.svh =====
// Assertion helpers for the mixer top level.
`ifndef OMNI_DRIVE_WHEEL_MIXER_MACROS_SVH
`define OMNI_DRIVE_WHEEL_MIXER_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define ODWM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odwm same-cycle check failed");

// Next-cycle implication, checked on every clock outside reset.
`define ODWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odwm next-cycle check failed");

`endif

// ===== hw/rtl/odwm_pkg.sv =====
package odwm_pkg;

    localparam int SINE_FRAC_BITS = 15;
    localparam int SINE_W  = SINE_FRAC_BITS + 1;
    localparam int MAG_W   = SINE_FRAC_BITS + 9;
    localparam int W_W     = MAG_W + 1;
    localparam int NUM_W   = MAG_W + 8;
    localparam int DSH_W   = MAG_W + 6;
    localparam int QTAB_N  = 91;
    localparam int ANGLE_W = 10;
    localparam logic [MAG_W-1:0] SCALE_MIN = MAG_W'((1 << SINE_FRAC_BITS) / 10);

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned HORNER_DIV [7] = '{210, 156, 110, 72, 42, 20, 6};

    localparam logic [ANGLE_W-1:0] WHEEL_OFFS [4] = '{10'd130, 10'd50, 10'd310, 10'd230};

    // Configuration register indexes
    localparam logic [1:0] CFG_STOP_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_IDLE_DUTY      = 2'd1;
    localparam logic [1:0] CFG_REVERSE_MASK   = 2'd2;
    localparam logic [1:0] CFG_INVERT_ON_HIGH = 2'd3;

    typedef logic [SINE_W-1:0] t_sine_tab [QTAB_N];

    // Quarter-wave sine, Q1.F, built from a truncated Taylor series in Q2.30
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        for (int k = 0; k < QTAB_N; k++) begin
            x  = (longint'(k) * PI_Q30) / 180;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int i = 0; i < 7; i++) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / HORNER_DIV[i];
            end
            s = (x * t) >> 30;
            s = (s + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
            tab[k] = s[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    // One classified command between front and back
    typedef struct packed {
        logic                   brake;
        logic                   scaled;
        logic [MAG_W-1:0]       peak;
        logic [3:0][NUM_W-1:0]  num;
        logic [3:0][7:0]        umag;
        logic [3:0]             neg;
    } t_cmd;

    // One finished result
    typedef struct packed {
        logic [3:0][7:0] duty;
        logic [3:0]      dir;
        logic            braking;
    } t_result;

    // Settings used by the back end
    typedef struct packed {
        logic [7:0] idle_duty;
        logic [3:0] reverse_mask;
        logic       invert_on_high;
    } t_back_cfg;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_back_state;

endpackage

// ===== hw/rtl/odwm_front.sv =====
module odwm_front
    import odwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [8:0]  i_heading_deg,
    input  logic [7:0]  i_speed,
    input  logic signed [8:0] i_turn,
    input  logic [7:0]  i_stop_threshold,
    output logic        o_push,
    input  logic        i_full,
    output t_cmd        o_cmd
);

    logic                    r_s1_v, r_s2_v;
    logic                    r_s1_brake, r_s2_brake;
    logic [7:0]              r_s1_speed, r_s2_speed;
    logic signed [8:0]       r_s1_turn, r_s2_turn;
    logic [SINE_W-1:0]       r_s1_smag [4];
    logic [3:0]              r_s1_sneg;
    logic signed [W_W-1:0]   r_s2_w [4];

    logic                    adv1, adv2;
    logic [8:0]              aturn_in;
    logic                    brake_in;
    logic [ANGLE_W-1:0]      a0, a;
    logic [SINE_W-1:0]       smag [4];
    logic [3:0]              sneg;
    logic signed [W_W-1:0]   w [4];
    logic [MAG_W-1:0]        m [4];
    logic [MAG_W-1:0]        pk01, pk23, peak;
    logic [8:0]              aturn2;
    logic [7:0]              target;
    logic                    scaled;

    // Fold a whole-degree angle below 720 onto the quarter table
    function automatic logic [SINE_W:0] sine_of(input logic [ANGLE_W-1:0] ang);
        logic [ANGLE_W-1:0] d;
        logic [6:0]         k;
        logic               ng;
        d  = (ang >= 10'd360) ? ang - 10'd360 : ang;
        ng = 1'b0;
        if (d <= 10'd90) begin
            k = d[6:0];
        end else if (d <= 10'd180) begin
            k = 7'(10'd180 - d);
        end else if (d <= 10'd270) begin
            k = 7'(d - 10'd180);
            ng = 1'b1;
        end else begin
            k = 7'(10'd360 - d);
            ng = 1'b1;
        end
        return {ng, SINE_TAB[k]};
    endfunction

    assign adv2    = !r_s2_v || !i_full;
    assign adv1    = !r_s1_v || adv2;
    assign o_ready = adv1;
    assign o_push  = r_s2_v && !i_full;

    // Classify brake, find wheel angles and sines
    assign aturn_in = i_turn[8] ? 9'(-i_turn) : i_turn;
    assign brake_in = ({1'b0, i_speed} < {1'b0, i_stop_threshold})
                   && (aturn_in < {1'b0, i_stop_threshold});
    assign a0 = 10'd630 - {1'b0, i_heading_deg};
    assign a  = (a0 >= 10'd360) ? a0 - 10'd360 : a0;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            {sneg[i], smag[i]} = sine_of(a + WHEEL_OFFS[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (adv1) begin
            r_s1_v <= i_valid;
        end
        if (adv1) begin
            r_s1_brake <= brake_in;
            r_s1_speed <= i_speed;
            r_s1_turn  <= i_turn;
            r_s1_sneg  <= sneg;
            for (int i = 0; i < 4; i++) begin
                r_s1_smag[i] <= smag[i];
            end
        end
    end

    // Form wheel values: speed times sine plus turn
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w[i] = r_s1_sneg[i]
                 ? (W_W'(r_s1_turn) <<< SINE_FRAC_BITS) - W_W'(r_s1_speed * r_s1_smag[i])
                 : (W_W'(r_s1_turn) <<< SINE_FRAC_BITS) + W_W'(r_s1_speed * r_s1_smag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (adv2) begin
            r_s2_v <= r_s1_v;
        end
        if (adv2) begin
            r_s2_brake <= r_s1_brake;
            r_s2_speed <= r_s1_speed;
            r_s2_turn  <= r_s1_turn;
            for (int i = 0; i < 4; i++) begin
                r_s2_w[i] <= w[i];
            end
        end
    end

    // Peak, target and scale numerators
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m[i] = r_s2_w[i][W_W-1] ? MAG_W'(-r_s2_w[i]) : MAG_W'(r_s2_w[i]);
        end
        pk01   = (m[0] > m[1]) ? m[0] : m[1];
        pk23   = (m[2] > m[3]) ? m[2] : m[3];
        peak   = (pk01 > pk23) ? pk01 : pk23;
        aturn2 = r_s2_turn[8] ? 9'(-r_s2_turn) : r_s2_turn;
        if ({1'b0, r_s2_speed} > aturn2) begin
            target = r_s2_speed;
        end else if (aturn2 > 9'd255) begin
            target = 8'd255;
        end else begin
            target = aturn2[7:0];
        end
        scaled = peak > SCALE_MIN;

        o_cmd.brake  = r_s2_brake;
        o_cmd.scaled = scaled;
        o_cmd.peak   = peak;
        for (int i = 0; i < 4; i++) begin
            o_cmd.num[i]  = NUM_W'(m[i] * target);
            o_cmd.umag[i] = (m[i][MAG_W-1:SINE_FRAC_BITS] > 9'd255)
                          ? 8'd255 : m[i][SINE_FRAC_BITS+7:SINE_FRAC_BITS];
            o_cmd.neg[i]  = r_s2_w[i][W_W-1] && !(scaled && target == 8'd0);
        end
    end

endmodule

// ===== hw/rtl/odwm_queue.sv =====
module odwm_queue
    import odwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rptr];

    // Store on push, advance read on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/odwm_back.sv =====
module odwm_back
    import odwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    input  t_back_cfg i_cfg,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_result
);

    t_back_state             r_state, n_state;
    logic [1:0]              r_cnt;
    logic                    r_brake, r_scaled;
    logic [3:0][7:0]         r_umag;
    logic [3:0]              r_neg;
    logic [NUM_W-1:0]        r_rem [4];
    logic [DSH_W-1:0]        r_dsh;
    logic [7:0]              r_q [4];
    logic                    r_out_v;
    t_result                 r_out;

    logic                    out_free, last, finish, step;
    logic [NUM_W-1:0]        t1 [4];
    logic [NUM_W-1:0]        rem1 [4];
    logic [NUM_W-1:0]        rem2 [4];
    logic [7:0]              q_next [4];
    logic [7:0]              mag [4];
    logic                    dir [4];
    logic                    b1, b0;
    t_result                 res;

    assign out_free = !r_out_v || i_ready;
    assign last     = r_cnt == 2'd3;
    assign finish   = (r_state == ST_DIV) && last && out_free;
    assign step     = (r_state == ST_DIV) && (!last || out_free);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = i_q_valid;
                if (i_q_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (finish) begin
                    o_pop = i_q_valid;
                    n_state = i_q_valid ? ST_DIV : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Two quotient bits per wheel each cycle, holding on the last step until the output is free, then finish the duty
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t1[i]   = NUM_W'({r_dsh, 1'b0});
            b1      = r_rem[i] >= t1[i];
            rem1[i] = b1 ? r_rem[i] - t1[i] : r_rem[i];
            b0      = rem1[i] >= NUM_W'(r_dsh);
            rem2[i] = b0 ? rem1[i] - NUM_W'(r_dsh) : rem1[i];
            q_next[i] = {r_q[i][5:0], b1, b0};

            mag[i] = r_scaled ? q_next[i] : r_umag[i];
            if (mag[i] < i_cfg.idle_duty) begin
                mag[i] = i_cfg.idle_duty;
            end
            dir[i] = i_cfg.reverse_mask[i] ? r_neg[i] : !r_neg[i];
            if (r_brake) begin
                res.duty[i] = i_cfg.idle_duty;
                res.dir[i]  = 1'b0;
            end else begin
                res.duty[i] = (dir[i] && i_cfg.invert_on_high) ? 8'd255 - mag[i] : mag[i];
                res.dir[i]  = dir[i];
            end
        end
        res.braking = r_brake;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (o_pop) begin
                r_cnt <= 2'd0;
            end else if (step) begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
        // Load a new command or advance the divide
        if (o_pop) begin
            r_brake  <= i_cmd.brake;
            r_scaled <= i_cmd.scaled;
            r_umag   <= i_cmd.umag;
            r_neg    <= i_cmd.neg;
            r_dsh    <= DSH_W'(i_cmd.peak) << 6;
            for (int i = 0; i < 4; i++) begin
                r_rem[i] <= i_cmd.num[i];
                r_q[i]   <= 8'd0;
            end
        end else if (step) begin
            r_dsh <= r_dsh >> 2;
            for (int i = 0; i < 4; i++) begin
                r_rem[i] <= rem2[i];
                r_q[i]   <= q_next[i];
            end
        end
        if (finish) begin
            r_out <= res;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/omni_drive_wheel_mixer.sv =====
// Four-wheel omni drive mixer.
// Input channel (i_valid/o_ready): heading in degrees, speed, signed turn.
// Output channel (o_valid/i_ready): four duty bytes, four direction levels and
// a braking flag, one result per command, in order.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 stop
// threshold, 1 idle duty, 2 reverse mask, 3 invert-on-high; write only while
// the block holds no command.
// Path from the accepting edge to o_valid: two front register stages, a queue
// write, a divider load and four divide steps.
// The back end's shared divider starts the next command only as it finishes the
// last, retiring two quotient bits per wheel each cycle unless the output stalls.
// A two-entry queue between the front pipeline and the divider lets the
// front keep accepting while the divider or the output stalls.
// When the receiver stalls, the result holds in the output register, the
// divider holds its last step, and the queue and front fill before o_ready
// drops. Reset empties the pipeline and restores register defaults.
`include "omni_drive_wheel_mixer_macros.svh"

module omni_drive_wheel_mixer
    import odwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [8:0]        i_heading_deg,
    input  logic [7:0]        i_speed,
    input  logic signed [8:0] i_turn,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_duty_front_right,
    output logic [7:0]        o_duty_back_right,
    output logic [7:0]        o_duty_back_left,
    output logic [7:0]        o_duty_front_left,
    output logic              o_dir_front_right,
    output logic              o_dir_back_right,
    output logic              o_dir_back_left,
    output logic              o_dir_front_left,
    output logic              o_braking,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    logic [7:0] r_stop_threshold;
    logic [7:0] r_idle_duty;
    logic [3:0] r_reverse_mask;
    logic       r_invert_on_high;

    logic       push, full, pop, q_valid;
    t_cmd       front_cmd, q_cmd;
    t_back_cfg  back_cfg;
    t_result    result;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_threshold <= 8'd5;
            r_idle_duty      <= 8'd1;
            r_reverse_mask   <= 4'd12;
            r_invert_on_high <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STOP_THRESHOLD: r_stop_threshold <= i_cfg_data;
                CFG_IDLE_DUTY:      r_idle_duty      <= i_cfg_data;
                CFG_REVERSE_MASK:   r_reverse_mask   <= i_cfg_data[3:0];
                CFG_INVERT_ON_HIGH: r_invert_on_high <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign back_cfg.idle_duty      = r_idle_duty;
    assign back_cfg.reverse_mask   = r_reverse_mask;
    assign back_cfg.invert_on_high = r_invert_on_high;

    odwm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_heading_deg    (i_heading_deg),
        .i_speed          (i_speed),
        .i_turn           (i_turn),
        .i_stop_threshold (r_stop_threshold),
        .o_push           (push),
        .i_full           (full),
        .o_cmd            (front_cmd)
    );

    odwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    odwm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .i_cfg     (back_cfg),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    assign o_duty_front_right = result.duty[0];
    assign o_duty_back_right  = result.duty[1];
    assign o_duty_back_left   = result.duty[2];
    assign o_duty_front_left  = result.duty[3];
    assign o_dir_front_right  = result.dir[0];
    assign o_dir_back_right   = result.dir[1];
    assign o_dir_back_left    = result.dir[2];
    assign o_dir_front_left   = result.dir[3];
    assign o_braking          = result.braking;

    `ODWM_ASSERT_IMPL(a_brake_dirs_low, o_valid && o_braking, result.dir == 4'd0)
    `ODWM_ASSERT_IMPL(a_brake_idle_duty, o_valid && o_braking, result.duty == {4{r_idle_duty}})
    `ODWM_ASSERT_IMPL(a_low_dir_min_duty, o_valid && !o_braking && !o_dir_front_right, o_duty_front_right >= r_idle_duty)
    `ODWM_ASSERT_NEXT(a_stalled_result_holds, o_valid && !i_ready, o_valid && $stable(result))

endmodule
